// ----- rtl/core/pet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_pkg
// shared types and codes for the pointer event translator
// ----------------------------------------------------------------------------
package pet_pkg;

    // defaults for the top level parameters
    localparam int BUTTON_COUNT_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // event kinds
    localparam logic [3:0] EV_UP    = 4'd0;
    localparam logic [3:0] EV_DOWN  = 4'd1;
    localparam logic [3:0] EV_DX    = 4'd2;
    localparam logic [3:0] EV_DY    = 4'd3;
    localparam logic [3:0] EV_ABS_X = 4'd4;
    localparam logic [3:0] EV_ABS_Y = 4'd5;
    localparam logic [3:0] EV_DZ    = 4'd6;
    localparam logic [3:0] EV_ABS_Z = 4'd7;
    localparam logic [3:0] EV_DW    = 4'd8;

    // result kinds
    localparam logic [1:0] RK_REL    = 2'd0;
    localparam logic [1:0] RK_ABS    = 2'd1;
    localparam logic [1:0] RK_BUTTON = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_X   = 3'd0;
    localparam logic [2:0] REG_MAX_X   = 3'd1;
    localparam logic [2:0] REG_MIN_Y   = 3'd2;
    localparam logic [2:0] REG_MAX_Y   = 3'd3;
    localparam logic [2:0] REG_INVERT  = 3'd4;
    localparam logic [2:0] REG_Z_WHEEL = 3'd5;
    localparam logic [2:0] REG_W_WHEEL = 3'd6;

    // special values
    localparam logic signed [15:0] IGNORED_ABS_X = 16'sd4095;
    localparam logic [5:0]         NO_WHEEL_MAP  = 6'd0;
    localparam int                 MAX_SLOTS     = 3;

    // one button change inside a descriptor
    typedef struct packed {
        logic [4:0] number;
        logic       pressed;
    } btn_slot_t;

    // everything the back end needs to emit the results of one item
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [17:0]      pos_x;
        logic signed [17:0]      pos_y;
        btn_slot_t [MAX_SLOTS-1:0] slots;
        logic [1:0]              count;
    } desc_t;

endpackage

// ----- rtl/core/pointer_event_translator.sv -----
`timescale 1ns / 1ps
// the queue is written at the edge that accepts an item, and the back end output register
// is loaded from the queue head once it is empty or being taken; further results of the
// same item follow one per cycle while the receiver takes them
// items with at most one result are taken one per cycle while the receiver keeps up; an
// item with several button results holds the back end until all are emitted, and the queue
// depth sets how far the front may run ahead. reset: synchronous active-low aresetn restores
// register defaults, clears held buttons, stored positions and the queue
// ----------------------------------------------------------------------------
// pointer_event_translator
// translates raw mouse events into motion and button change results
// ----------------------------------------------------------------------------
module pointer_event_translator import pet_pkg::*; #(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_event_kind,
    input  logic signed [15:0] s_event_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic signed [17:0] m_pos_x,
    output logic signed [17:0] m_pos_y,
    output logic [4:0]         m_button_number,
    output logic               m_pressed,
    output logic               m_last_of_run
);

    logic  push_valid, push_ready, head_valid, head_pop;
    desc_t push_data, head;

    // classification and state
    pet_front #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_event_kind  (s_event_kind),
        .s_event_value (s_event_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    // descriptor queue
    pet_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_data   (head)
    );

    // result emission
    pet_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head            (head),
        .head_pop        (head_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_button_number (m_button_number),
        .m_pressed       (m_pressed),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

// ----- rtl/core/pet_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_front
// accepts events, holds configuration and pointer state, builds descriptors
// ----------------------------------------------------------------------------
module pet_front import pet_pkg::*; #(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_event_kind,
    input  logic signed [15:0] s_event_value,
    output logic               push_valid,
    input  logic               push_ready,
    output desc_t              push_data
);

    localparam logic [5:0] BC_NUM = 6'(BUTTON_COUNT);

    // one-hot mask of button number n, n in 1..32
    function automatic logic [31:0] btn_bit(input logic [5:0] n);
        logic [4:0] idx;
        idx = 5'(n - 6'd1);
        return 32'd1 << idx;
    endfunction

    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [1:0]         invert_reg;
    logic [11:0]        z_wheel_reg, w_wheel_reg;
    logic [31:0]        held_reg, held_next;
    logic signed [17:0] abs_x_reg, abs_x_next, abs_y_reg, abs_y_next;

    logic               accept;
    logic signed [17:0] val_s, abs_a;
    logic [5:0]         btn_num;
    logic [31:0]        btn_mask, btn_new;
    logic [11:0]        wmap;
    logic [5:0]         wneg, wpos, wlo, whi, wchosen;
    logic               wheel_ok;
    logic [31:0]        wchosen_m, wnext;
    logic               cand_v [MAX_SLOTS];
    btn_slot_t          cand   [MAX_SLOTS];
    logic [1:0]         fill;
    desc_t              desc;

    assign s_ready    = push_ready;
    assign accept     = s_valid & s_ready;
    assign push_valid = accept & (desc.count != 2'd0);
    assign push_data  = desc;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg   <= 16'sd0;
            max_x_reg   <= 16'sd1023;
            min_y_reg   <= 16'sd0;
            max_y_reg   <= 16'sd767;
            invert_reg  <= 2'd0;
            z_wheel_reg <= 12'd0;
            w_wheel_reg <= 12'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_X:   min_x_reg   <= cfg_wdata;
                REG_MAX_X:   max_x_reg   <= cfg_wdata;
                REG_MIN_Y:   min_y_reg   <= cfg_wdata;
                REG_MAX_Y:   max_y_reg   <= cfg_wdata;
                REG_INVERT:  invert_reg  <= cfg_wdata[1:0];
                REG_Z_WHEEL: z_wheel_reg <= cfg_wdata[11:0];
                REG_W_WHEEL: w_wheel_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // operand decode for buttons and wheels
    always_comb begin
        val_s    = 18'(s_event_value);
        btn_num  = {1'b0, s_event_value[4:0]} + 6'd1;
        btn_mask = 32'd1 << s_event_value[4:0];
        btn_new  = (s_event_kind == EV_DOWN) ? (held_reg | btn_mask) : (held_reg & ~btn_mask);

        wmap      = (s_event_kind == EV_DW) ? w_wheel_reg : z_wheel_reg;
        wneg      = wmap[5:0];
        wpos      = wmap[11:6];
        wheel_ok  = (wneg != NO_WHEEL_MAP) && (wpos != NO_WHEEL_MAP) &&
                    (wneg <= BC_NUM) && (wpos <= BC_NUM);
        wlo       = (wneg < wpos) ? wneg : wpos;
        whi       = (wneg < wpos) ? wpos : wneg;
        wchosen   = s_event_value[15] ? wneg : wpos;
        wchosen_m = btn_bit(wchosen);
        wnext     = (held_reg & ~(btn_bit(wneg) | btn_bit(wpos))) | wchosen_m;
    end

    // classification and state update
    always_comb begin
        desc       = '0;
        held_next  = held_reg;
        abs_x_next = abs_x_reg;
        abs_y_next = abs_y_reg;
        abs_a      = val_s;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            cand_v[i] = 1'b0;
            cand[i]   = '0;
        end

        case (s_event_kind)
            EV_UP, EV_DOWN: begin
                desc.kind = RK_BUTTON;
                if (!s_event_value[15] && (s_event_value <= 16'sd30)) begin
                    held_next      = btn_new;
                    cand_v[0]      = (btn_new != held_reg) && (btn_num < BC_NUM);
                    cand[0].number = btn_num[4:0];
                    cand[0].pressed = (s_event_kind == EV_DOWN);
                end
            end
            EV_DX: begin
                desc.kind  = RK_REL;
                desc.pos_x = val_s;
                desc.count = (s_event_value != 16'sd0) ? 2'd1 : 2'd0;
            end
            EV_DY: begin
                desc.kind  = RK_REL;
                desc.pos_y = -val_s;
                desc.count = (s_event_value != 16'sd0) ? 2'd1 : 2'd0;
            end
            EV_ABS_X: begin
                desc.kind = RK_ABS;
                if (invert_reg[0])
                    abs_a = 18'(max_x_reg) - val_s + 18'(min_x_reg);
                desc.pos_x = abs_a;
                desc.pos_y = abs_y_reg;
                if ((s_event_value != IGNORED_ABS_X) && (abs_a != 18'sd0)) begin
                    desc.count = 2'd1;
                    abs_x_next = abs_a;
                end
            end
            EV_ABS_Y: begin
                desc.kind = RK_ABS;
                if (invert_reg[1])
                    abs_a = 18'(max_y_reg) - val_s + 18'(min_y_reg);
                desc.pos_x = abs_x_reg;
                desc.pos_y = abs_a;
                if (abs_a != 18'sd0) begin
                    desc.count = 2'd1;
                    abs_y_next = abs_a;
                end
            end
            EV_DZ, EV_DW: begin
                desc.kind = RK_BUTTON;
                if (wheel_ok && (s_event_value != 16'sd0)) begin
                    // changes of the two mapped buttons, ascending, then the release
                    held_next       = wnext & ~wchosen_m;
                    cand_v[0]       = ((held_reg & btn_bit(wlo)) != (wnext & btn_bit(wlo))) &&
                                      (wlo < BC_NUM);
                    cand[0].number  = wlo[4:0];
                    cand[0].pressed = ((wnext & btn_bit(wlo)) != 32'd0);
                    cand_v[1]       = (whi != wlo) &&
                                      ((held_reg & btn_bit(whi)) != (wnext & btn_bit(whi))) &&
                                      (whi < BC_NUM);
                    cand[1].number  = whi[4:0];
                    cand[1].pressed = ((wnext & btn_bit(whi)) != 32'd0);
                    cand_v[2]       = (wchosen < BC_NUM);
                    cand[2].number  = wchosen[4:0];
                    cand[2].pressed = 1'b0;
                end
            end
            default: ;
        endcase

        // pack the button changes into consecutive slots
        fill = 2'd0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (cand_v[i]) begin
                desc.slots[fill] = cand[i];
                fill             = fill + 2'd1;
            end
        end
        if (desc.kind == RK_BUTTON)
            desc.count = fill;
    end

    // pointer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 32'd0;
            abs_x_reg <= 18'sd0;
            abs_y_reg <= 18'sd0;
        end else if (accept) begin
            held_reg  <= held_next;
            abs_x_reg <= abs_x_next;
            abs_y_reg <= abs_y_next;
        end
    end

endmodule

// ----- rtl/core/pet_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_queue
// short descriptor queue between front and back end
// ----------------------------------------------------------------------------
module pet_queue import pet_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_data,
    output logic  pop_valid,
    input  logic  pop,
    output desc_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/core/pet_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_back
// expands descriptors into result items, one per cycle while m_ready allows, into an output register
// ----------------------------------------------------------------------------
module pet_back import pet_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  desc_t              head,
    output logic               head_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic signed [17:0] m_pos_x,
    output logic signed [17:0] m_pos_y,
    output logic [4:0]         m_button_number,
    output logic               m_pressed,
    output logic               m_last_of_run
);

    logic               m_valid_reg;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         kind_reg;
    logic signed [17:0] pos_x_reg, pos_y_reg;
    logic [4:0]         number_reg;
    logic               pressed_reg, last_reg;
    logic               load, is_last;

    assign load     = head_valid & (~m_valid_reg | m_ready);
    assign is_last  = (idx_reg == head.count - 2'd1);
    assign head_pop = load & is_last;
    assign idx_next = head_pop ? 2'd0 : idx_reg + 2'd1;

    // slot counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg    <= head.kind;
            pos_x_reg   <= head.pos_x;
            pos_y_reg   <= head.pos_y;
            number_reg  <= head.slots[idx_reg].number;
            pressed_reg <= head.slots[idx_reg].pressed;
            last_reg    <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_pos_x         = pos_x_reg;
    assign m_pos_y         = pos_y_reg;
    assign m_button_number = number_reg;
    assign m_pressed       = pressed_reg;
    assign m_last_of_run   = last_reg;

endmodule

// ----- tb/sv/pet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_checker
// watches the event and result channels of the pointer event translator,
// predicts the results of every accepted event and compares them in order
// ----------------------------------------------------------------------------
module pet_checker import pet_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_event_kind,
    input  logic signed [15:0] s_event_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_result_kind,
    input  logic signed [17:0] m_pos_x,
    input  logic signed [17:0] m_pos_y,
    input  logic [4:0]         m_button_number,
    input  logic               m_pressed,
    input  logic               m_last_of_run,
    output int                 fail_count,
    output int                 results_pending
);

    // highest button index an up or down event may name
    localparam int MAX_BUTTON_INDEX = 30;
    localparam int RESULTS_PER_EVENT = 4;

    typedef struct {
        logic [1:0]         kind;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic [4:0]         button;
        logic               pressed;
        logic               last;
    } pointer_result_t;

    pointer_result_t expected_results[$];
    pointer_result_t event_results[$];

    // shadow of the configuration registers
    logic signed [15:0] min_x, max_x, min_y, max_y;
    logic [1:0]         invert_axes;
    logic [11:0]        z_map, w_map;

    // shadow of the translator state
    logic [31:0] held_mask;
    int          abs_x_last, abs_y_last;
    int          errors = 0;

    function automatic pointer_result_t make_result(logic [1:0] k, int px, int py, int btn,
                                                    logic prs);
        pointer_result_t r;
        r.kind    = k;
        r.pos_x   = px[17:0];
        r.pos_y   = py[17:0];
        r.button  = btn[4:0];
        r.pressed = prs;
        r.last    = 1'b0;
        return r;
    endfunction

    // report changed buttons in ascending order, then take the new mask
    task automatic report_buttons(input logic [31:0] next);
        for (int b = 1; b < BUTTON_COUNT_DEF; b++) begin
            if (held_mask[b-1] != next[b-1] && event_results.size() < RESULTS_PER_EVENT)
                event_results.push_back(make_result(RK_BUTTON, 0, 0, b, next[b-1]));
        end
        held_mask = next;
    endtask

    // wheel delta: clear both mapped buttons, press the chosen one, then release it
    task automatic spin_wheel(input logic [11:0] map, input int delta);
        int          neg_btn, pos_btn;
        logic [31:0] next, chosen;
        neg_btn = map[5:0];
        pos_btn = map[11:6];
        if (delta == 0 || neg_btn == int'(NO_WHEEL_MAP) || pos_btn == int'(NO_WHEEL_MAP) ||
            neg_btn > BUTTON_COUNT_DEF || pos_btn > BUTTON_COUNT_DEF)
            return;
        chosen = 32'd1 << ((delta < 0 ? neg_btn : pos_btn) - 1);
        next = (held_mask & ~((32'd1 << (neg_btn - 1)) | (32'd1 << (pos_btn - 1)))) | chosen;
        if (next != held_mask)
            report_buttons(next);
        report_buttons(next & ~chosen);
    endtask

    // work out the results of one event and queue them
    task automatic translate_event(input logic [3:0] kind, input logic signed [15:0] value);
        int          v, a;
        logic [31:0] next;
        v = value;
        event_results.delete();
        case (kind)
            EV_UP, EV_DOWN: begin
                if (v >= 0 && v <= MAX_BUTTON_INDEX) begin
                    next = (kind == EV_DOWN) ? (held_mask | (32'd1 << v))
                                             : (held_mask & ~(32'd1 << v));
                    if (next != held_mask)
                        report_buttons(next);
                end
            end
            EV_DX: begin
                if (v != 0)
                    event_results.push_back(make_result(RK_REL, v, 0, 0, 1'b0));
            end
            EV_DY: begin
                if (v != 0)
                    event_results.push_back(make_result(RK_REL, 0, -v, 0, 1'b0));
            end
            EV_ABS_X: begin
                if (value != IGNORED_ABS_X) begin
                    a = invert_axes[0] ? int'(max_x) - v + int'(min_x) : v;
                    if (a != 0) begin
                        event_results.push_back(make_result(RK_ABS, a, abs_y_last, 0, 1'b0));
                        abs_x_last = a;
                    end
                end
            end
            EV_ABS_Y: begin
                a = invert_axes[1] ? int'(max_y) - v + int'(min_y) : v;
                if (a != 0) begin
                    event_results.push_back(make_result(RK_ABS, abs_x_last, a, 0, 1'b0));
                    abs_y_last = a;
                end
            end
            EV_DZ: spin_wheel(z_map, v);
            EV_DW: spin_wheel(w_map, v);
            default: ;
        endcase
        if (event_results.size() > 0)
            event_results[event_results.size() - 1].last = 1'b1;
        foreach (event_results[i])
            expected_results.push_back(event_results[i]);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // track configuration, compare results, predict accepted items
    always @(posedge aclk) begin
        pointer_result_t want;
        if (!aresetn) begin
            min_x = 16'sd0;
            max_x = 16'sd1023;
            min_y = 16'sd0;
            max_y = 16'sd767;
            invert_axes = 2'd0;
            z_map = 12'd0;
            w_map = 12'd0;
            held_mask = 32'd0;
            abs_x_last = 0;
            abs_y_last = 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_X:   min_x = cfg_wdata;
                    REG_MAX_X:   max_x = cfg_wdata;
                    REG_MIN_Y:   min_y = cfg_wdata;
                    REG_MAX_Y:   max_y = cfg_wdata;
                    REG_INVERT:  invert_axes = cfg_wdata[1:0];
                    REG_Z_WHEEL: z_map = cfg_wdata[11:0];
                    REG_W_WHEEL: w_map = cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: kind %0d x %0d y %0d button %0d",
                           m_result_kind, m_pos_x, m_pos_y, m_button_number);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, m_result_kind);
                    check_field("pos_x", want.pos_x, m_pos_x);
                    check_field("pos_y", want.pos_y, m_pos_y);
                    check_field("button_number", want.button, m_button_number);
                    check_field("pressed", want.pressed, m_pressed);
                    check_field("last_of_run", want.last, m_last_of_run);
                end
            end
            if (s_valid && s_ready)
                translate_event(s_event_kind, s_event_value);
        end
        fail_count <= errors;
        results_pending <= expected_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives mouse events and register settings into the pointer event translator
// under varying idle patterns and back-pressure; the checker predicts and
// compares every result
// ----------------------------------------------------------------------------
module testbench;
    import pet_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam int         PHASE_ITEMS     = 55;
    localparam int         PHASE_COUNT     = 6;
    localparam int         SETTLE_CYCLES   = 4;
    localparam logic [2:0] REG_UNUSED      = 3'd7;
    localparam logic [3:0] EV_UNKNOWN_TOP  = 4'd15;
    localparam logic [3:0] EV_UNKNOWN_LOW  = 4'd9;
    localparam logic [15:0] INVERT_NONE    = 16'd0;
    localparam logic [15:0] INVERT_BOTH    = 16'd3;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = REG_MIN_X;
    logic [15:0]        cfg_wdata = 16'd0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_event_kind = EV_UP;
    logic signed [15:0] s_event_value = 16'sd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_result_kind;
    logic signed [17:0] m_pos_x;
    logic signed [17:0] m_pos_y;
    logic [4:0]         m_button_number;
    logic               m_pressed;
    logic               m_last_of_run;

    int fail_count;
    int results_pending;
    int send_idle_pct = 17;
    int recv_idle_pct = 50;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    // register values as last written, used to aim events at special cases
    logic signed [15:0] cur_min_x = 16'sd0, cur_max_x = 16'sd1023;
    logic signed [15:0] cur_min_y = 16'sd0, cur_max_y = 16'sd767;

    pointer_event_translator DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_event_kind(s_event_kind),
        .s_event_value(s_event_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_pos_x(m_pos_x),
        .m_pos_y(m_pos_y),
        .m_button_number(m_button_number),
        .m_pressed(m_pressed),
        .m_last_of_run(m_last_of_run)
    );

    pet_checker result_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_event_kind(s_event_kind),
        .s_event_value(s_event_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_pos_x(m_pos_x),
        .m_pos_y(m_pos_y),
        .m_button_number(m_button_number),
        .m_pressed(m_pressed),
        .m_last_of_run(m_last_of_run),
        .fail_count(fail_count),
        .results_pending(results_pending)
    );

    // clock
    always #10 aclk = ~aclk;

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item after a random gap and wait until it is taken
    task automatic send_event(input logic [3:0] kind, input logic signed [15:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_event_kind <= kind;
        s_event_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] minx, maxx, miny, maxy, inv, zmap, wmap);
        write_reg(REG_MIN_X, minx);
        write_reg(REG_MAX_X, maxx);
        write_reg(REG_MIN_Y, miny);
        write_reg(REG_MAX_Y, maxy);
        write_reg(REG_INVERT, inv);
        write_reg(REG_Z_WHEEL, zmap);
        write_reg(REG_W_WHEEL, wmap);
        write_reg(REG_UNUSED, 16'($urandom()));
        cfg_wr_en <= 1'b0;
        cur_min_x = minx;
        cur_max_x = maxx;
        cur_min_y = miny;
        cur_max_y = maxy;
        @(posedge aclk);
    endtask

    // wheel map with both buttons in the usable range
    function automatic logic [11:0] valid_wheel_map();
        return {6'($urandom_range(BUTTON_COUNT_DEF, 1)), 6'($urandom_range(BUTTON_COUNT_DEF, 1))};
    endfunction

    function automatic logic [15:0] random_word();
        return 16'($urandom());
    endfunction

    // mostly meaningful events with random content, some noise
    task automatic send_random_event();
        int                 pick;
        logic [3:0]         kind;
        logic signed [15:0] value;
        pick = $urandom_range(99);
        value = random_word();
        if (pick < 30) begin
            kind = $urandom_range(1) ? EV_DOWN : EV_UP;
            if ($urandom_range(9) != 0)
                value = 16'($urandom_range(30));
        end else if (pick < 45) begin
            kind = $urandom_range(1) ? EV_DX : EV_DY;
            if ($urandom_range(9) == 0)
                value = 16'sd0;
            else if ($urandom_range(1))
                value = 16'(int'($urandom_range(64)) - 32);
        end else if (pick < 65) begin
            kind = $urandom_range(1) ? EV_ABS_X : EV_ABS_Y;
            case ($urandom_range(7))
                0: value = IGNORED_ABS_X;
                1: value = 16'sd0;
                2: value = (kind == EV_ABS_X) ? 16'(int'(cur_max_x) + int'(cur_min_x))
                                              : 16'(int'(cur_max_y) + int'(cur_min_y));
                default: ;
            endcase
        end else if (pick < 90) begin
            kind = $urandom_range(1) ? EV_DZ : EV_DW;
            if ($urandom_range(9) == 0)
                value = 16'sd0;
            else if ($urandom_range(1))
                value = 16'(int'($urandom_range(16)) - 8);
        end else begin
            kind = $urandom_range(1) ? EV_ABS_Z : 4'($urandom_range(EV_UNKNOWN_TOP, EV_UNKNOWN_LOW));
        end
        send_event(kind, value);
    endtask

    // stimulus and verdict
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: buttons, motion extremes, ignored events
        send_event(EV_DOWN, 16'sd0);
        send_event(EV_DOWN, 16'sd30);
        send_event(EV_UP, 16'sd30);
        send_event(EV_DOWN, 16'sd31);
        send_event(EV_UP, -16'sd32768);
        send_event(EV_DOWN, 16'sd0);
        send_event(EV_DX, 16'sd32767);
        send_event(EV_DX, -16'sd32768);
        send_event(EV_DY, -16'sd32768);
        send_event(EV_DY, 16'sd0);
        send_event(EV_ABS_X, IGNORED_ABS_X);
        send_event(EV_ABS_X, -16'sd32768);
        send_event(EV_ABS_Y, 16'sd32767);
        send_event(EV_ABS_Y, 16'sd0);
        send_event(EV_DZ, 16'sd5);
        send_event(EV_ABS_Z, 16'sd100);
        send_event(EV_UNKNOWN_TOP, 16'sd1);
        drain_results();

        // inverted axes and mapped wheels
        write_config(16'd100, 16'd900, -16'sd50, 16'd50, INVERT_BOTH,
                     16'({6'd3, 6'd2}), 16'({6'd32, 6'd31}));
        send_event(EV_ABS_X, 16'sd1000);
        send_event(EV_ABS_X, IGNORED_ABS_X);
        send_event(EV_ABS_X, 16'sd1);
        send_event(EV_ABS_Y, 16'sd10);
        send_event(EV_DZ, -16'sd1);
        send_event(EV_DZ, 16'sd7);
        send_event(EV_DOWN, 16'sd1);
        send_event(EV_DZ, 16'sd3);
        send_event(EV_DW, -16'sd32768);
        send_event(EV_DW, 16'sd1);
        send_event(EV_DW, 16'sd0);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // idle pattern: sender light, then receiver light, then none
            if (phase < 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 50;
            end else if (phase < 4) begin
                send_idle_pct = 50;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: write_config(random_word(), random_word(), random_word(), random_word(),
                                random_word(), {4'($urandom()), valid_wheel_map()},
                                {4'($urandom()), valid_wheel_map()});
                1: write_config(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, INVERT_BOTH,
                                16'({6'd1, 6'd32}), 16'({6'd32, 6'd1}));
                2: write_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, INVERT_BOTH,
                                16'({6'd31, 6'd31}), 16'hFFFF);
                3: write_config(random_word(), random_word(), random_word(), random_word(),
                                INVERT_NONE, {4'd0, valid_wheel_map()}, 16'd0);
                4: write_config(random_word(), random_word(), random_word(), random_word(),
                                random_word(), {4'd0, valid_wheel_map()},
                                {4'd0, valid_wheel_map()});
                default: write_config(random_word(), random_word(), random_word(),
                                      random_word(), random_word(), random_word(),
                                      random_word());
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long receiver hold-off while items keep coming
                if (phase == 4 && i == 10)
                    hold_asks <= hold_asks + 1;
                // sender waits for every result part-way through
                if (phase == 1 && i == 25)
                    drain_results();
                send_random_event();
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
